@@ src/bks_pkg.sv @@
// bks_pkg: shared types, constants and tables for the bicycle kinematics step block
// depends on nothing; imported by bicycle_kinematics_step
`timescale 1ns / 1ps

package bks_pkg;

  localparam int TRIG_STEPS   = 16;
  localparam int CORDIC_MAX   = 24;
  localparam int CORDIC_ITERS = (TRIG_STEPS < CORDIC_MAX) ? TRIG_STEPS : CORDIC_MAX;

  localparam int PI_Q       = 205887;
  localparam int HALF_PI_Q  = 102944;
  localparam int TWO_PI_Q   = 2 * PI_Q;

  // start value of the rotation, inverse of the converged gain in q2.30
  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

  // offset that makes any pre-wrap heading positive, a multiple of the period plus pi
  localparam int WRAP_SHIFTS = 14;
  localparam logic [34:0] WRAP_BIAS = 35'(PI_Q) + 35'(TWO_PI_Q) * 35'd8192;

  localparam int DIV_BITS = 48;

  localparam logic [2:0] REG_MAX_ACCEL = 3'd0;
  localparam logic [2:0] REG_MAX_STEER = 3'd1;
  localparam logic [2:0] REG_MAX_VEL   = 3'd2;
  localparam logic [2:0] REG_WHEEL     = 3'd3;
  localparam logic [2:0] REG_INIT_X    = 3'd4;
  localparam logic [2:0] REG_INIT_Y    = 3'd5;
  localparam logic [2:0] REG_INIT_HD   = 3'd6;
  localparam logic [2:0] REG_INIT_SPD  = 3'd7;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_RELOAD  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MVC,
    ST_MCD,
    ST_MVS,
    ST_MSD,
    ST_MACC,
    ST_MVST,
    ST_DIV_LD,
    ST_DIV,
    ST_MYAW,
    ST_WRAP_LD,
    ST_WRAP,
    ST_FIN
  } bks_state_t;

  // arctangent of 2^-i in q2.30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837830;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // saturate a 35 bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/bicycle_kinematics_step.sv @@
// bicycle_kinematics_step: pose and speed update, one time step per input word
// uses bks_pkg; one shared multiplier, cordic, divider and wrap step under one sequencer
`timescale 1ns / 1ps

//  channel   direction  handshake                  payload
//  in        sink       in_valid / in_stall        opcode steer_cmd speed_cmd step_len
//  out       source     out_valid / out_stall      pos_x pos_y heading speed yaw_rate steer_used
//  cfg       apb slave  psel penable pwrite pready paddr pwdata prdata
//
//  an advance word runs the cordic loop, the passes through the one multiplier, a
//  bit-serial divide of the 48 bit product and a 14 step heading wrap; a reload
//  word runs the wrap and the finish state
//  the sequencer returns to idle after each word before the next one is taken
//  in_stall is high from acceptance until the result is moved to the output register
//  the result register frees the core, so the next word is taken while out is stalled
//  rst is synchronous and loads the default registers and a zero pose
module bicycle_kinematics_step
  import bks_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [19:0] steer_cmd,
  input  logic signed [31:0] speed_cmd,
  input  logic [15:0]        step_len,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [18:0] heading,
  output logic signed [31:0] speed,
  output logic signed [31:0] yaw_rate,
  output logic signed [17:0] steer_used,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [30:0]        max_acceleration;
  logic [16:0]        max_steering;
  logic [30:0]        max_velocity;
  logic [30:0]        wheel_base;
  logic signed [31:0] init_x;
  logic signed [31:0] init_y;
  logic signed [18:0] init_heading;
  logic signed [31:0] init_speed;

  // pose state
  logic signed [31:0] x_reg;
  logic signed [31:0] y_reg;
  logic signed [18:0] heading_reg;
  logic signed [31:0] speed_reg;

  // sequencer
  bks_state_t state, state_next;
  logic [5:0] cnt;

  // latched command
  logic signed [31:0] speed_cmd_r;
  logic [15:0]        dt_r;
  logic signed [17:0] steer_r;

  // cordic registers, q2.30
  logic signed [33:0] cx, cy, cz;
  logic               cneg;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [67:0] prod;

  // divider
  logic [47:0] dvd;
  logic [30:0] rem;
  logic        qneg;

  // results waiting for the finish state
  logic signed [31:0] vel_r;
  logic signed [31:0] yaw_r;
  logic [33:0]        wrap_r;

  logic in_accept;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      max_acceleration <= 31'd65536;
      max_steering     <= 17'd32768;
      max_velocity     <= 31'd655360;
      wheel_base       <= 31'd65536;
      init_x           <= '0;
      init_y           <= '0;
      init_heading     <= '0;
      init_speed       <= '0;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_MAX_ACCEL: max_acceleration <= pwdata[30:0];
        REG_MAX_STEER: max_steering     <= pwdata[16:0];
        REG_MAX_VEL:   max_velocity     <= pwdata[30:0];
        REG_WHEEL:     wheel_base       <= pwdata[30:0];
        REG_INIT_X:    init_x           <= pwdata;
        REG_INIT_Y:    init_y           <= pwdata;
        REG_INIT_HD:   init_heading     <= pwdata[18:0];
        REG_INIT_SPD:  init_speed       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MAX_ACCEL: prdata = {1'b0, max_acceleration};
      REG_MAX_STEER: prdata = {15'd0, max_steering};
      REG_MAX_VEL:   prdata = {1'b0, max_velocity};
      REG_WHEEL:     prdata = {1'b0, wheel_base};
      REG_INIT_X:    prdata = init_x;
      REG_INIT_Y:    prdata = init_y;
      REG_INIT_HD:   prdata = 32'(init_heading);
      REG_INIT_SPD:  prdata = init_speed;
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- datapath helpers
  // heading folded into [-pi/2, pi/2] for the rotation
  logic signed [19:0] hd_fold;
  logic               hd_neg;
  always_comb begin
    hd_neg  = 1'b0;
    hd_fold = 20'(heading_reg);
    if (heading_reg > 19'sd102944) begin
      hd_fold = 20'(heading_reg) - 20'sd205887;
      hd_neg  = 1'b1;
    end else if (heading_reg < -19'sd102944) begin
      hd_fold = 20'(heading_reg) + 20'sd205887;
      hd_neg  = 1'b1;
    end
  end

  // steering clamp done at accept
  logic signed [20:0] steer_lim;
  logic signed [17:0] steer_clamped;
  always_comb begin
    steer_lim = 21'($signed({1'b0, max_steering}));
    if (21'(steer_cmd) > steer_lim) begin
      steer_clamped = steer_lim[17:0];
    end else if (21'(steer_cmd) < -steer_lim) begin
      steer_clamped = 18'(-steer_lim);
    end else begin
      steer_clamped = steer_cmd[17:0];
    end
  end

  // cordic step, shifter shared across iterations
  logic signed [33:0] cdx, cdy, catan;
  assign cdx   = cy >>> cnt[4:0];
  assign cdy   = cx >>> cnt[4:0];
  assign catan = atan_q30(cnt[4:0]);

  logic signed [33:0] cos_v, sin_v;
  assign cos_v = cneg ? -cx : cx;
  assign sin_v = cneg ? -cy : cy;

  // product taps
  logic signed [33:0] prod_hi30, prod_lo16;
  assign prod_hi30 = prod[63:30];
  assign prod_lo16 = prod[49:16];

  // speed change clamp
  logic signed [32:0] acc_diff, acc_lim;
  logic signed [31:0] accel;
  always_comb begin
    acc_diff = 33'(speed_cmd_r) - 33'(speed_reg);
    acc_lim  = 33'($signed({1'b0, max_acceleration}));
    if (acc_diff > acc_lim) begin
      accel = acc_lim[31:0];
    end else if (acc_diff < -acc_lim) begin
      accel = 32'(-acc_lim);
    end else begin
      accel = acc_diff[31:0];
    end
  end

  // new speed clamp
  logic signed [34:0] vel_sum, vel_lim;
  logic signed [31:0] vel_clamped;
  always_comb begin
    vel_sum = 35'(speed_reg) + 35'(prod_lo16);
    vel_lim = 35'($signed({1'b0, max_velocity}));
    if (vel_sum > vel_lim) begin
      vel_clamped = vel_lim[31:0];
    end else if (vel_sum < -vel_lim) begin
      vel_clamped = 32'(-vel_lim);
    end else begin
      vel_clamped = vel_sum[31:0];
    end
  end

  // restoring divide step, zero wheel base counts as one
  logic [30:0] wb_eff;
  logic [31:0] rem_sh, rem_sub;
  logic        div_ge;
  assign wb_eff  = (wheel_base == '0) ? 31'd1 : wheel_base;
  assign rem_sh  = {rem, dvd[47]};
  assign div_ge  = (rem_sh >= {1'b0, wb_eff});
  assign rem_sub = rem_sh - {1'b0, wb_eff};

  // quotient to signed yaw rate with saturation
  logic signed [31:0] yaw_sat;
  always_comb begin
    if (qneg) begin
      yaw_sat = (dvd > 48'd2147483648) ? 32'sh80000000 : 32'(-$signed({1'b0, dvd}));
    end else begin
      yaw_sat = (dvd > 48'd2147483647) ? 32'sh7FFFFFFF : dvd[31:0];
    end
  end

  // heading wrap: subtract shifted periods, largest first
  logic [3:0]  wrap_k;
  logic [33:0] wrap_step;
  assign wrap_k    = 4'(WRAP_SHIFTS - 1) - cnt[3:0];
  assign wrap_step = 34'(TWO_PI_Q) << wrap_k;

  logic signed [34:0] hd_sum, hd_init;
  assign hd_sum  = 35'(heading_reg) + 35'(prod_lo16) + $signed(WRAP_BIAS);
  assign hd_init = 35'(init_heading) + $signed(WRAP_BIAS);

  // ---------------------------------------------------------------- multiplier operands
  always_comb begin
    case (state)
      ST_MVC:  begin mul_a = 34'(speed_reg); mul_b = cos_v; end
      ST_MCD:  begin mul_a = prod_hi30;      mul_b = 34'($signed({1'b0, dt_r})); end
      ST_MVS:  begin mul_a = 34'(speed_reg); mul_b = sin_v; end
      ST_MSD:  begin mul_a = prod_hi30;      mul_b = 34'($signed({1'b0, dt_r})); end
      ST_MACC: begin mul_a = 34'(accel);     mul_b = 34'($signed({1'b0, dt_r})); end
      ST_MVST: begin mul_a = 34'(speed_reg); mul_b = 34'(steer_r); end
      ST_MYAW: begin mul_a = 34'(yaw_sat);   mul_b = 34'($signed({1'b0, dt_r})); end
      default: begin mul_a = '0;             mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (opcode == OP_RELOAD) ? ST_WRAP : ST_CORDIC;
        end
      end
      ST_CORDIC:  if (cnt == 6'(CORDIC_ITERS - 1)) state_next = ST_MVC;
      ST_MVC:     state_next = ST_MCD;
      ST_MCD:     state_next = ST_MVS;
      ST_MVS:     state_next = ST_MSD;
      ST_MSD:     state_next = ST_MACC;
      ST_MACC:    state_next = ST_MVST;
      ST_MVST:    state_next = ST_DIV_LD;
      ST_DIV_LD:  state_next = ST_DIV;
      ST_DIV:     if (cnt == 6'(DIV_BITS - 1)) state_next = ST_MYAW;
      ST_MYAW:    state_next = ST_WRAP_LD;
      ST_WRAP_LD: state_next = ST_WRAP;
      ST_WRAP:    if (cnt == 6'(WRAP_SHIFTS - 1)) state_next = ST_FIN;
      ST_FIN:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_reg       <= '0;
      y_reg       <= '0;
      heading_reg <= '0;
      speed_reg   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_accept) begin
            if (opcode == OP_RELOAD) begin
              x_reg   <= init_x;
              y_reg   <= init_y;
              vel_r   <= init_speed;
              yaw_r   <= '0;
              steer_r <= '0;
              wrap_r  <= hd_init[33:0];
            end else begin
              speed_cmd_r <= speed_cmd;
              dt_r        <= step_len;
              steer_r     <= steer_clamped;
              cx          <= CORDIC_INV_GAIN;
              cy          <= '0;
              cz          <= {hd_fold, 14'd0};
              cneg        <= hd_neg;
            end
          end
        end
        ST_CORDIC: begin
          if (!cz[33]) begin
            cx <= cx - cdx;
            cy <= cy + cdy;
            cz <= cz - catan;
          end else begin
            cx <= cx + cdx;
            cy <= cy - cdy;
            cz <= cz + catan;
          end
          cnt <= (cnt == 6'(CORDIC_ITERS - 1)) ? '0 : cnt + 6'd1;
        end
        ST_MVC, ST_MCD, ST_MSD: prod <= mul_p;
        ST_MVS: begin
          x_reg <= sat32(35'(x_reg) + 35'(prod_lo16));
          prod  <= mul_p;
        end
        ST_MACC: begin
          y_reg <= sat32(35'(y_reg) + 35'(prod_lo16));
          prod  <= mul_p;
        end
        ST_MVST: begin
          vel_r <= vel_clamped;
          prod  <= mul_p;
        end
        ST_DIV_LD: begin
          qneg <= prod[67];
          dvd  <= prod[67] ? 48'(-prod) : prod[47:0];
          rem  <= '0;
          cnt  <= '0;
        end
        ST_DIV: begin
          dvd <= {dvd[46:0], div_ge};
          rem <= div_ge ? rem_sub[30:0] : rem_sh[30:0];
          cnt <= (cnt == 6'(DIV_BITS - 1)) ? '0 : cnt + 6'd1;
        end
        ST_MYAW: begin
          yaw_r <= yaw_sat;
          prod  <= mul_p;
        end
        ST_WRAP_LD: wrap_r <= hd_sum[33:0];
        ST_WRAP: begin
          if (wrap_r >= wrap_step) wrap_r <= wrap_r - wrap_step;
          cnt <= cnt + 6'd1;
        end
        ST_FIN: begin
          if (out_free) begin
            heading_reg <= 19'(wrap_r - 34'(PI_Q));
            speed_reg   <= vel_r;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- result register
  logic out_load;
  assign out_load = (state == ST_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x      <= x_reg;
      pos_y      <= y_reg;
      heading    <= 19'(wrap_r - 34'(PI_Q));
      speed      <= vel_r;
      yaw_rate   <= yaw_r;
      steer_used <= steer_r;
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state != ST_IDLE)
    else $error("accepted word did not start the sequencer");

  a_cordic_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_CORDIC |-> cnt < 6'(CORDIC_ITERS))
    else $error("cordic iteration count out of range");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result shown outside the finish state");

  a_wrap_in_period: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> wrap_r < 34'(TWO_PI_Q))
    else $error("heading wrap left a value beyond one period");
`endif

endmodule

@@ sim/bicycle_kinematics_step_tb.sv @@
// bicycle_kinematics_step_tb: self-checking bench for the bicycle kinematics step block
// depends on bks_pkg and bicycle_kinematics_step; predicts each result word in-bench
`timescale 1ns / 1ps

module bicycle_kinematics_step_tb;
  import bks_pkg::*;

  // bench-side copy of the arctangent table, q2.30
  localparam longint ATAN_TBL [24] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};
  localparam longint GAIN_Q30 = 652032874;
  localparam longint PI_L = 205887;
  localparam longint HALF_PI_L = 102944;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic               op;
    logic signed [19:0] steer;
    logic signed [31:0] spd;
    logic [15:0]        dt;
  } cmd_word_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [18:0] hd;
    logic signed [31:0] sp;
    logic signed [31:0] yaw;
    logic signed [17:0] st;
  } pose_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic opcode = OP_ADVANCE;
  logic signed [19:0] steer_cmd = '0;
  logic signed [31:0] speed_cmd = '0;
  logic [15:0] step_len = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, speed, yaw_rate;
  logic signed [18:0] heading;
  logic signed [17:0] steer_used;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bicycle_kinematics_step u_top (.*);

  // model state and register copies
  longint acc_lim, steer_lim, vel_lim, wb_len, ix, iy, ihd, ispd;
  longint cur_x, cur_y, cur_hd, cur_spd;

  cmd_word_t  cmd_q[$];
  pose_word_t pose_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;   // offered word was accepted at the last rising edge
  int hold_off = 0;      // long receiver hold-off, counted here
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int burst_left = 0, gap_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clampsym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint wrap_heading(longint h);
    longint r;
    r = (h + PI_L) % (2 * PI_L);
    if (r < 0) r += 2 * PI_L;
    return r - PI_L;
  endfunction

  // fixed-iteration rotation; angles past +-pi/2 folded by pi and negated
  function automatic void sin_cos(input longint h, output longint c, output longint s);
    bit neg;
    longint x, y, z, dx, dy;
    neg = 0; x = GAIN_Q30; y = 0;
    if (h > HALF_PI_L) begin
      h -= PI_L; neg = 1;
    end else if (h < -HALF_PI_L) begin
      h += PI_L; neg = 1;
    end
    z = h * 16384;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = asr(y, i); dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic void reload_pose();
    cur_x = ix; cur_y = iy; cur_hd = wrap_heading(ihd); cur_spd = ispd;
  endfunction

  // advance the pose by one word and queue what the block should emit
  function automatic void predict_pose(cmd_word_t w);
    longint c, s, acc, vel, wb, yaw, st, dt;
    pose_word_t e;
    yaw = 0; st = 0;
    if (w.op == OP_RELOAD) begin
      reload_pose();
    end else begin
      dt = w.dt;
      sin_cos(cur_hd, c, s);
      cur_x = sat32(cur_x + asr(asr(cur_spd * c, 30) * dt, 16));
      cur_y = sat32(cur_y + asr(asr(cur_spd * s, 30) * dt, 16));
      acc = clampsym(longint'(w.spd) - cur_spd, acc_lim);
      st = clampsym(w.steer, steer_lim);
      vel = clampsym(cur_spd + asr(acc * dt, 16), vel_lim);
      wb = (wb_len != 0) ? wb_len : 1;
      yaw = sat32((cur_spd * st) / wb);
      cur_hd = wrap_heading(cur_hd + asr(yaw * dt, 16));
      cur_spd = vel;
    end
    e.px = cur_x[31:0]; e.py = cur_y[31:0]; e.hd = cur_hd[18:0];
    e.sp = cur_spd[31:0]; e.yaw = yaw[31:0]; e.st = st[17:0];
    pose_q.push_back(e);
  endfunction

  // driver: bursts of words with random gaps, payload held until taken
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_taken) begin
        // hold
      end else begin
        if (gap_left > 0) gap_left--;
        if (cmd_q.size() > 0 && gap_left == 0) begin
          in_valid <= 1'b1;
          opcode <= cmd_q[0].op; steer_cmd <= cmd_q[0].steer;
          speed_cmd <= cmd_q[0].spd; step_len <= cmd_q[0].dt;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: long hold-off once, then its own random pattern
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_off = 3000;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // monitor: accept at the rising edge, predict inputs and check outputs
  always @(posedge clk) begin
    if (!rst) begin
      in_taken = in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        predict_pose(cmd_q.pop_front());
      end
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected result word, pos_x %0d", $time, pos_x);
          errors++;
        end else begin
          pose_word_t e;
          e = pose_q.pop_front();
          if (pos_x !== e.px) begin
            $display("%0t: pos_x exp %0d got %0d", $time, e.px, pos_x); errors++;
          end
          if (pos_y !== e.py) begin
            $display("%0t: pos_y exp %0d got %0d", $time, e.py, pos_y); errors++;
          end
          if (heading !== e.hd) begin
            $display("%0t: heading exp %0d got %0d", $time, e.hd, heading); errors++;
          end
          if (speed !== e.sp) begin
            $display("%0t: speed exp %0d got %0d", $time, e.sp, speed); errors++;
          end
          if (yaw_rate !== e.yaw) begin
            $display("%0t: yaw_rate exp %0d got %0d", $time, e.yaw, yaw_rate); errors++;
          end
          if (steer_used !== e.st) begin
            $display("%0t: steer_used exp %0d got %0d", $time, e.st, steer_used); errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // register write over apb: setup then access, on falling edges
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MAX_ACCEL: acc_lim = val[30:0];
      REG_MAX_STEER: steer_lim = val[16:0];
      REG_MAX_VEL:   vel_lim = val[30:0];
      REG_WHEEL:     wb_len = val[30:0];
      REG_INIT_X:    ix = longint'(signed'(val));
      REG_INIT_Y:    iy = longint'(signed'(val));
      REG_INIT_HD:   ihd = longint'(signed'(val[18:0]));
      REG_INIT_SPD:  ispd = longint'(signed'(val));
      default: ;
    endcase
  endtask

  function automatic void queue_cmd(logic op, logic signed [19:0] st,
                                    logic signed [31:0] sp, logic [15:0] dt);
    cmd_word_t w;
    w.op = op; w.steer = st; w.spd = sp; w.dt = dt;
    cmd_q.push_back(w);
  endfunction

  // random word: mostly plausible driving, some full-range noise and some reloads
  function automatic void queue_random();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) queue_cmd(OP_RELOAD, 20'($urandom), $urandom, 16'($urandom));
    else if (k < 4) queue_cmd(OP_ADVANCE, 20'($urandom), $urandom, 16'($urandom));
    else queue_cmd(OP_ADVANCE, $signed(20'($urandom_range(0, 200000))) - 20'sd100000,
                   $signed($urandom_range(0, 2000000)) - 32'sd1000000,
                   16'($urandom_range(0, 8000)));
  endfunction

  // wait until every word has been sent and its result checked, then let the block settle
  task automatic drain();
    while (cmd_q.size() > 0 || pose_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    acc_lim = 65536; steer_lim = 32768; vel_lim = 655360; wb_len = 65536;
    ix = 0; iy = 0; ihd = 0; ispd = 0;
    reload_pose();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: defaults, then field extremes and each special case
    queue_cmd(OP_ADVANCE, 20'sd10000, 32'sd131072, 16'd65535);
    queue_cmd(OP_ADVANCE, 20'sh7FFFF, 32'sh7FFFFFFF, 16'hFFFF);
    queue_cmd(OP_ADVANCE, 20'sh80000, 32'sh80000000, 16'hFFFF);
    queue_cmd(OP_ADVANCE, 20'sd5000, 32'sd0, 16'd0);          // zero step
    queue_cmd(OP_RELOAD, 20'sh7FFFF, 32'sh7FFFFFFF, 16'hFFFF);
    drain();

    // extremes: speed over the limit, out-of-range heading, zero wheel base
    write_reg(REG_MAX_ACCEL, 32'h7FFFFFFF);
    write_reg(REG_MAX_STEER, 32'd102944);
    write_reg(REG_MAX_VEL, 32'd1000);
    write_reg(REG_WHEEL, 32'd0);
    write_reg(REG_INIT_X, 32'h7FFFFFF0);
    write_reg(REG_INIT_Y, 32'h80000010);
    write_reg(REG_INIT_HD, 32'h0003FFFF);
    write_reg(REG_INIT_SPD, 32'h7FFFFFFF);
    queue_cmd(OP_RELOAD, '0, '0, '0);
    queue_cmd(OP_ADVANCE, 20'sh7FFFF, 32'sh7FFFFFFF, 16'hFFFF);
    queue_cmd(OP_ADVANCE, 20'sh80000, 32'sh80000000, 16'hFFFF);
    drain();
    write_reg(REG_INIT_HD, 32'h00040000);  // most negative heading
    write_reg(REG_INIT_SPD, 32'h80000000);
    queue_cmd(OP_RELOAD, '0, '0, '0);
    queue_cmd(OP_ADVANCE, 20'sd102944, 32'sd0, 16'hFFFF);
    queue_cmd(OP_ADVANCE, -20'sd102944, 32'sd0, 16'h8000);
    drain();

    // random phases under several settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_MAX_ACCEL, (ph == 0) ? 32'd0 : $urandom_range(0, 32'h7FFFFFFF));
      write_reg(REG_MAX_STEER, (ph == 1) ? 32'd0 : $urandom_range(0, 102944));
      write_reg(REG_MAX_VEL, (ph == 2) ? 32'h7FFFFFFF : $urandom_range(0, 4000000));
      write_reg(REG_WHEEL, (ph == 3) ? 32'd1 : $urandom_range(1, 32'h7FFFFFFF));
      write_reg(REG_INIT_X, $urandom);
      write_reg(REG_INIT_Y, $urandom);
      write_reg(REG_INIT_HD, $urandom_range(0, 32'h7FFFF));
      write_reg(REG_INIT_SPD, $signed($urandom_range(0, 4000000)) - 32'sd2000000);
      queue_cmd(OP_RELOAD, '0, '0, '0);
      for (int n = 0; n < 300; n++) queue_random();
      if (ph == 1) hold_armed = 1'b1;
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
